>>> design/spcc_pkg.sv
// spcc_pkg: shared types, constants and fixed-point helpers of the pairwise-coupling classifier
`default_nettype none
package spcc_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int PAIR_COUNT  = (NUM_CLASSES * (NUM_CLASSES - 1)) / 2;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);

   localparam logic signed [31:0] Q_ONE     = 32'sh4000_0000;
   localparam logic signed [63:0] Q_HALF    = 64'sh0000_0000_2000_0000;
   localparam logic signed [31:0] Q_MAX     = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
   localparam logic signed [31:0] Q_UNIFORM = 32'sh1000_0000;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_MAX_ITER = 3'd0;
   localparam logic [2:0] CSR_STOP_TOL = 3'd1;
   localparam logic [2:0] CSR_LABEL_0  = 3'd2;
   localparam logic [2:0] CSR_LABEL_1  = 3'd3;
   localparam logic [2:0] CSR_LABEL_2  = 3'd4;
   localparam logic [2:0] CSR_LABEL_3  = 3'd5;

   localparam logic [7:0]  RESET_MAX_ITER = 8'd100;
   localparam logic [15:0] RESET_STOP_TOL = 16'd82;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_QB_SQ,
      ST_QB_SQ_ACC,
      ST_QB_OFF,
      ST_IT_START,
      ST_QP_MUL,
      ST_QP_ACC,
      ST_PQP_MUL,
      ST_PQP_ACC,
      ST_ERR,
      ST_DIFF_GO,
      ST_DIFF_WAIT,
      ST_MUL1,
      ST_INNER,
      ST_MUL2,
      ST_PQ1_GO,
      ST_PQ1_WAIT,
      ST_PQ2_GO,
      ST_PQ2_WAIT,
      ST_QJ_MUL,
      ST_QJ_GO,
      ST_QJ_WAIT,
      ST_PJ_GO,
      ST_PJ_WAIT,
      ST_FINISH
   } state_type;

   // saturate a wide value to q2.30
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'(Q_MAX)) begin
         return Q_MAX;
      end else if (x < 64'(Q_MIN)) begin
         return Q_MIN;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] addq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(64'(a) + 64'(b));
   endfunction

   function automatic logic signed [31:0] subq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(64'(a) - 64'(b));
   endfunction

   function automatic logic signed [31:0] negq(input logic signed [31:0] a);
      return sat32(-64'(a));
   endfunction

   // round a full product half up to q2.30, then saturate
   function automatic logic signed [31:0] mulq(input logic signed [63:0] prod);
      logic signed [63:0] x;
      x = prod + Q_HALF;
      return sat32(x >>> 30);
   endfunction

   // q2.30 to q0.16 with rounding and clamping
   function automatic logic [15:0] to_q16(input logic signed [31:0] x);
      logic signed [32:0] r;
      if (x <= 0) begin
         return 16'd0;
      end
      r = (33'(x) + 33'sd8192) >>> 14;
      if (r > 33'sd65535) begin
         return 16'hffff;
      end
      return r[15:0];
   endfunction

endpackage
`default_nettype wire

>>> design/spcc_div.sv
// spcc_div: iterative signed q2.30 divider, one quotient bit per cycle, saturating
`default_nettype none
module spcc_div
   import spcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    done,
   output logic signed [31:0]      quot
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] sh_ff, sh_in;
   logic [30:0] acc_ff, acc_in;
   logic [31:0] ad_ff, ad_in;
   logic        neg_ff, neg_in;
   logic signed [31:0] quot_ff, quot_in;

   logic [31:0] an;
   logic [31:0] ad;
   logic [32:0] trial;
   logic        ge;
   logic [32:0] diff;

   // magnitudes of the operands
   assign an = num[31] ? 32'(-33'(num)) : num;
   assign ad = den[31] ? 32'(-33'(den)) : den;

   // one restoring step
   assign trial = {rem_ff, sh_ff[30]};
   assign ge    = trial >= {1'b0, ad_ff};
   assign diff  = trial - {1'b0, ad_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      ad_in   = ad_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         if (den == 32'sd0) begin
            quot_in = num[31] ? Q_MIN : Q_MAX;
            done_in = 1'b1;
         end else if ({1'b0, an} >= {ad, 1'b0}) begin
            quot_in = (num[31] ^ den[31]) ? Q_MIN : Q_MAX;
            done_in = 1'b1;
         end else begin
            run_in = 1'b1;
            cnt_in = 5'd30;
            rem_in = {1'b0, an[31:1]};
            sh_in  = {an[0], 30'd0};
            acc_in = '0;
            ad_in  = ad;
            neg_in = num[31] ^ den[31];
         end
      end else if (run_ff) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         sh_in  = {sh_ff[29:0], 1'b0};
         acc_in = {acc_ff[29:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? -$signed({1'b0, acc_in}) : $signed({1'b0, acc_in});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      ad_ff   <= ad_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> design/svm_pairwise_coupling_classifier_top.sv
// svm_pairwise_coupling_classifier_top: sequenced pairwise-coupling class probability estimator
// operation: builds the coupling matrix, then runs coupling iterations, then reports the result
//   (44 divisions per iteration on the shared divider;
//   the iteration that converges stops before any division)
// transfers: one transfer at a time; busy drops with the result strobe; receiver cannot stall
// reset: synchronous; registers return to 100 iterations, tolerance 82, labels 1..4
`default_nettype none
module svm_pairwise_coupling_classifier_top
   import spcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_prob_pair_01,
   input  wire logic [15:0] req_prob_pair_02,
   input  wire logic [15:0] req_prob_pair_03,
   input  wire logic [15:0] req_prob_pair_12,
   input  wire logic [15:0] req_prob_pair_13,
   input  wire logic [15:0] req_prob_pair_23,
   output logic             rsp_valid,
   output logic [15:0]      rsp_class_prob_0,
   output logic [15:0]      rsp_class_prob_1,
   output logic [15:0]      rsp_class_prob_2,
   output logic [15:0]      rsp_class_prob_3,
   output logic [1:0]       rsp_winning_index,
   output logic [7:0]       rsp_winning_label,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   localparam logic [CLASS_W-1:0] LAST = CLASS_W'(NUM_CLASSES - 1);

   state_type state_ff, state_in;

   logic [7:0]  max_iter_ff, max_iter_in;
   logic [15:0] stop_tol_ff, stop_tol_in;
   logic [7:0]  label_ff [NUM_CLASSES];
   logic [7:0]  label_in [NUM_CLASSES];

   logic [15:0]        pair_ff [PAIR_COUNT];
   logic [15:0]        pair_in [PAIR_COUNT];
   logic signed [31:0] cq_ff [NUM_CLASSES][NUM_CLASSES];
   logic signed [31:0] cq_in [NUM_CLASSES][NUM_CLASSES];
   logic signed [31:0] p_ff [NUM_CLASSES];
   logic signed [31:0] p_in [NUM_CLASSES];
   logic signed [31:0] qp_ff [NUM_CLASSES];
   logic signed [31:0] qp_in [NUM_CLASSES];
   logic signed [31:0] pqp_ff, pqp_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [31:0] onep_ff, onep_in;
   logic signed [31:0] inner_ff, inner_in;
   logic signed [31:0] maxerr_ff, maxerr_in;
   logic signed [63:0] prod_ff;
   logic [7:0]         iter_ff, iter_in;
   logic [CLASS_W-1:0] b_ff, b_in;
   logic [CLASS_W-1:0] j_ff, j_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] prob_ff [NUM_CLASSES];
   logic [15:0] prob_in [NUM_CLASSES];
   logic [1:0]  win_ff, win_in;
   logic [7:0]  wlabel_ff, wlabel_in;

   logic signed [31:0] mul_a, mul_b;
   logic               div_start;
   logic signed [31:0] div_num, div_den;
   logic               div_done;
   logic signed [31:0] div_quot;

   logic               use_j;
   logic [CLASS_W-1:0] col;
   logic signed [31:0] p_rd, qp_rd, cq_rd, cq_diag;
   logic signed [31:0] mq;
   logic signed [31:0] r_jb, r_bj;

   // pair probability r_xy in q2.30, x != y
   function automatic logic signed [31:0] pair_val(input logic [15:0] pr [PAIR_COUNT],
                                                   input logic [CLASS_W-1:0] x,
                                                   input logic [CLASS_W-1:0] y);
      logic [CLASS_W-1:0] lo;
      logic [CLASS_W-1:0] hi;
      logic [15:0]        v;
      logic signed [31:0] r;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      case ({lo, hi})
         {2'd0, 2'd1}: v = pr[0];
         {2'd0, 2'd2}: v = pr[1];
         {2'd0, 2'd3}: v = pr[2];
         {2'd1, 2'd2}: v = pr[3];
         {2'd1, 2'd3}: v = pr[4];
         {2'd2, 2'd3}: v = pr[5];
         default:      v = 16'd0;
      endcase
      r = {2'b00, v, 14'd0};
      return (x < y) ? r : Q_ONE - r;
   endfunction

   spcc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // single read port per working array; the finish state reads p directly
   assign use_j = (state_ff == ST_QP_MUL) || (state_ff == ST_QJ_MUL) ||
                  (state_ff == ST_QJ_GO) || (state_ff == ST_PJ_GO);
   assign col     = use_j ? j_ff : b_ff;
   assign p_rd    = p_ff[col];
   assign qp_rd   = qp_ff[col];
   assign cq_rd   = cq_ff[b_ff][col];
   assign cq_diag = cq_rd;
   assign mq      = mulq(prod_ff);
   assign r_jb    = pair_val(pair_ff, j_ff, b_ff);
   assign r_bj    = pair_val(pair_ff, b_ff, j_ff);

   // shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // sequencer
   always_comb begin
      logic signed [31:0] t;
      logic signed [32:0] e;
      logic signed [31:0] ae;
      logic signed [31:0] m;
      logic [1:0]         w;
      state_in    = state_ff;
      max_iter_in = max_iter_ff;
      stop_tol_in = stop_tol_ff;
      label_in    = label_ff;
      pair_in     = pair_ff;
      cq_in       = cq_ff;
      p_in        = p_ff;
      qp_in       = qp_ff;
      pqp_in      = pqp_ff;
      acc_in      = acc_ff;
      diff_in     = diff_ff;
      onep_in     = onep_ff;
      inner_in    = inner_ff;
      maxerr_in   = maxerr_ff;
      iter_in     = iter_ff;
      b_in        = b_ff;
      j_in        = j_ff;
      rsp_valid_in = 1'b0;
      prob_in     = prob_ff;
      win_in      = win_ff;
      wlabel_in   = wlabel_ff;
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = '0;
      t           = '0;
      e           = '0;
      ae          = '0;
      m           = '0;
      w           = '0;

      // configuration writes
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_ITER: max_iter_in = csr_write_data[7:0];
            CSR_STOP_TOL: stop_tol_in = csr_write_data;
            CSR_LABEL_0:  label_in[0] = csr_write_data[7:0];
            CSR_LABEL_1:  label_in[1] = csr_write_data[7:0];
            CSR_LABEL_2:  label_in[2] = csr_write_data[7:0];
            CSR_LABEL_3:  label_in[3] = csr_write_data[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pair_in[0] = req_prob_pair_01;
               pair_in[1] = req_prob_pair_02;
               pair_in[2] = req_prob_pair_03;
               pair_in[3] = req_prob_pair_12;
               pair_in[4] = req_prob_pair_13;
               pair_in[5] = req_prob_pair_23;
               for (int i = 0; i < NUM_CLASSES; i++) begin
                  p_in[i] = Q_UNIFORM;
               end
               acc_in   = '0;
               b_in     = '0;
               j_in     = '0;
               iter_in  = '0;
               state_in = ST_QB_SQ;
            end
         end

         // coupling matrix build, acc holds the diagonal sum
         ST_QB_SQ, ST_QB_OFF: begin
            if (state_ff == ST_QB_OFF) begin
               cq_in[b_ff][j_ff] = negq(mq);
            end
            if (state_ff == ST_QB_SQ && j_ff != b_ff) begin
               mul_a    = r_jb;
               mul_b    = r_jb;
               state_in = ST_QB_SQ_ACC;
            end else if (j_ff == LAST) begin
               cq_in[b_ff][b_ff] = acc_ff;
               acc_in = '0;
               j_in   = '0;
               if (b_ff == LAST) begin
                  state_in = ST_IT_START;
               end else begin
                  b_in     = b_ff + 1'b1;
                  state_in = ST_QB_SQ;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_QB_SQ;
            end
         end
         ST_QB_SQ_ACC: begin
            acc_in   = addq(acc_ff, mq);
            mul_a    = r_jb;
            mul_b    = r_bj;
            state_in = ST_QB_OFF;
         end

         ST_IT_START: begin
            if (iter_ff >= max_iter_ff) begin
               state_in = ST_FINISH;
            end else begin
               pqp_in   = '0;
               acc_in   = '0;
               b_in     = '0;
               j_in     = '0;
               state_in = ST_QP_MUL;
            end
         end

         // qp = q * p, pqp = p' * qp
         ST_QP_MUL: begin
            mul_a    = cq_rd;
            mul_b    = p_rd;
            state_in = ST_QP_ACC;
         end
         ST_QP_ACC: begin
            t = addq(acc_ff, mq);
            if (j_ff == LAST) begin
               qp_in[b_ff] = t;
               acc_in   = '0;
               j_in     = '0;
               state_in = ST_PQP_MUL;
            end else begin
               acc_in   = t;
               j_in     = j_ff + 1'b1;
               state_in = ST_QP_MUL;
            end
         end
         ST_PQP_MUL: begin
            mul_a    = p_rd;
            mul_b    = qp_rd;
            state_in = ST_PQP_ACC;
         end
         ST_PQP_ACC: begin
            pqp_in = addq(pqp_ff, mq);
            if (b_ff == LAST) begin
               b_in      = '0;
               maxerr_in = '0;
               state_in  = ST_ERR;
            end else begin
               b_in     = b_ff + 1'b1;
               state_in = ST_QP_MUL;
            end
         end

         // largest error, one class per cycle
         ST_ERR: begin
            e  = 33'(qp_rd) - 33'(pqp_ff);
            if (e < 0) begin
               e = -e;
            end
            ae = sat32(64'(e));
            m  = (ae > maxerr_ff) ? ae : maxerr_ff;
            maxerr_in = m;
            if (b_ff == LAST) begin
               b_in = '0;
               if (m < $signed({2'b00, stop_tol_ff, 14'd0})) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIFF_GO;
               end
            end else begin
               b_in = b_ff + 1'b1;
            end
         end

         // per-class update
         ST_DIFF_GO: begin
            div_start = 1'b1;
            div_num   = subq(pqp_ff, qp_rd);
            div_den   = cq_diag;
            state_in  = ST_DIFF_WAIT;
         end
         ST_DIFF_WAIT: begin
            if (div_done) begin
               diff_in    = div_quot;
               onep_in    = addq(Q_ONE, div_quot);
               p_in[b_ff] = addq(p_rd, div_quot);
               state_in   = ST_MUL1;
            end
         end
         ST_MUL1: begin
            mul_a    = diff_ff;
            mul_b    = cq_diag;
            state_in = ST_INNER;
         end
         ST_INNER: begin
            inner_in = addq(mq, addq(qp_rd, qp_rd));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a    = diff_ff;
            mul_b    = inner_ff;
            state_in = ST_PQ1_GO;
         end
         ST_PQ1_GO: begin
            div_start = 1'b1;
            div_num   = addq(pqp_ff, mq);
            div_den   = onep_ff;
            state_in  = ST_PQ1_WAIT;
         end
         ST_PQ1_WAIT: begin
            if (div_done) begin
               state_in = ST_PQ2_GO;
            end
         end
         ST_PQ2_GO: begin
            div_start = 1'b1;
            div_num   = div_quot;
            div_den   = onep_ff;
            state_in  = ST_PQ2_WAIT;
         end
         ST_PQ2_WAIT: begin
            if (div_done) begin
               pqp_in   = div_quot;
               j_in     = '0;
               state_in = ST_QJ_MUL;
            end
         end
         ST_QJ_MUL: begin
            mul_a    = diff_ff;
            mul_b    = cq_rd;
            state_in = ST_QJ_GO;
         end
         ST_QJ_GO: begin
            div_start = 1'b1;
            div_num   = addq(qp_rd, mq);
            div_den   = onep_ff;
            state_in  = ST_QJ_WAIT;
         end
         ST_QJ_WAIT: begin
            if (div_done) begin
               qp_in[j_ff] = div_quot;
               state_in    = ST_PJ_GO;
            end
         end
         ST_PJ_GO: begin
            div_start = 1'b1;
            div_num   = p_rd;
            div_den   = onep_ff;
            state_in  = ST_PJ_WAIT;
         end
         ST_PJ_WAIT: begin
            if (div_done) begin
               p_in[j_ff] = div_quot;
               if (j_ff == LAST) begin
                  j_in = '0;
                  if (b_ff == LAST) begin
                     b_in     = '0;
                     iter_in  = iter_ff + 8'd1;
                     state_in = ST_IT_START;
                  end else begin
                     b_in     = b_ff + 1'b1;
                     state_in = ST_DIFF_GO;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_QJ_MUL;
               end
            end
         end

         // argmax and result transfer
         ST_FINISH: begin
            w = 2'd0;
            for (int i = 1; i < NUM_CLASSES; i++) begin
               if (p_ff[i] > p_ff[w]) begin
                  w = 2'(i);
               end
            end
            for (int i = 0; i < NUM_CLASSES; i++) begin
               prob_in[i] = to_q16(p_ff[i]);
            end
            win_in       = w;
            wlabel_in    = label_ff[w];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_iter_ff  <= RESET_MAX_ITER;
         stop_tol_ff  <= RESET_STOP_TOL;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            label_ff[i] <= 8'(i + 1);
         end
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         max_iter_ff  <= max_iter_in;
         stop_tol_ff  <= stop_tol_in;
         label_ff     <= label_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
      end
      pair_ff   <= pair_in;
      cq_ff     <= cq_in;
      p_ff      <= p_in;
      qp_ff     <= qp_in;
      pqp_ff    <= pqp_in;
      acc_ff    <= acc_in;
      diff_ff   <= diff_in;
      onep_ff   <= onep_in;
      inner_ff  <= inner_in;
      maxerr_ff <= maxerr_in;
      b_ff      <= b_in;
      j_ff      <= j_in;
      prob_ff   <= prob_in;
      win_ff    <= win_in;
      wlabel_ff <= wlabel_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_prob_0  = prob_ff[0];
   assign rsp_class_prob_1  = prob_ff[1];
   assign rsp_class_prob_2  = prob_ff[2];
   assign rsp_class_prob_3  = prob_ff[3];
   assign rsp_winning_index = win_ff;
   assign rsp_winning_label = wlabel_ff;

endmodule
`default_nettype wire
